>>> rtl/tpu_pkg.sv
// ============================================================================
// tpu_pkg - shared types and constants of the tile pixel unpacker
// Register indexes, channel modes, operation codes, controller states and
// the command and status bundles between controller and datapath.
// ============================================================================
package tpu_pkg;

    // Rows of the alpha region in colour mode, also the alpha row stride
    localparam int ALPHA_TILE = 64;

    // Width of computed store addresses, wide enough for every decode
    localparam int ADDR_W = 21;

    // Pixel index and alpha row base widths
    localparam int PIX_W   = 16;
    localparam int YBASE_W = 15;

    // Configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd4;

    // Channel modes (code three decodes as grey)
    localparam logic [1:0] MODE_ALPHA  = 2'd0;
    localparam logic [1:0] MODE_GREY   = 2'd1;
    localparam logic [1:0] MODE_COLOUR = 2'd2;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Fetch slots in colour mode
    localparam logic [1:0] SLOT_BLUE  = 2'd0;
    localparam logic [1:0] SLOT_GREEN = 2'd1;
    localparam logic [1:0] SLOT_RED   = 2'd2;
    localparam logic [1:0] SLOT_ALPHA = 2'd3;

    // Last fetch slot per mode
    localparam logic [1:0] LAST_COLOUR = 2'd3;
    localparam logic [1:0] LAST_GREY   = 2'd1;
    localparam logic [1:0] LAST_ALPHA  = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_FETCH,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]  channel_mode;
        logic        one_bit;
        logic [16:0] plane_bytes;
        logic [8:0]  tile_width;
        logic [8:0]  tile_height;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic       mem_wr;
        logic       load;
        logic       calc;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       result;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic       out_of_range;
        logic [1:0] last_sel;
    } stat_t;

endpackage

>>> rtl/tpu_cfg.sv
// ============================================================================
// tpu_cfg - configuration registers
// Holds the mode, packing, plane offset and tile size written over the
// configuration channel. Writes to unknown indexes are dropped.
// ============================================================================
module tpu_cfg
    import tpu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always able to take a write
    assign cfg_ready = 1'b1;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHANNEL_MODE: cfg_next.channel_mode = cfg_data[1:0];
                REG_ONE_BIT:      cfg_next.one_bit      = cfg_data[0];
                REG_PLANE_BYTES:  cfg_next.plane_bytes  = cfg_data[16:0];
                REG_TILE_WIDTH:   cfg_next.tile_width   = cfg_data[8:0];
                REG_TILE_HEIGHT:  cfg_next.tile_height  = cfg_data[8:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_mode <= MODE_COLOUR;
            cfg_reg.one_bit      <= 1'b0;
            cfg_reg.plane_bytes  <= 17'd65536;
            cfg_reg.tile_width   <= 9'd256;
            cfg_reg.tile_height  <= 9'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/tpu_ctrl.sv
// ============================================================================
// tpu_ctrl - transaction controller
// Accepts commands, sequences the index calculation, the store reads of a
// pixel and the result strobe.
// ============================================================================
module tpu_ctrl
    import tpu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  op,
    output logic  busy,
    output logic  done,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       done_reg;
    logic       done_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && op == OP_READ)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cnt_next = 2'd0;
                if (stat.out_of_range)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (cnt_reg == stat.last_sel)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl        = '0;
        ctl.rd_sel = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.mem_wr = start && op == OP_WRITE;
                ctl.load   = start && op == OP_READ;
            end
            ST_CALC:
            begin
                ctl.calc = 1'b1;
            end
            ST_FETCH:
            begin
                ctl.rd_en = 1'b1;
            end
            ST_RESULT:
            begin
                ctl.result = 1'b1;
                done_next  = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = state_reg != ST_IDLE;
    assign done = done_reg;

endmodule

>>> rtl/tpu_datapath.sv
// ============================================================================
// tpu_datapath - byte store and pixel decode
// Byte store with one port, address generation per mode, fetch slots and
// the RGBA result registers.
// ============================================================================
module tpu_datapath
    import tpu_pkg::*;
#(
    parameter int STORE_BYTES  = 524288,
    parameter int MAX_TILE_DIM = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  ctl_t        ctl,
    output stat_t       stat,
    input  logic [18:0] byte_index,
    input  logic [7:0]  byte_value,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        out_of_range
);

    localparam int                AW          = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] STORE_LIMIT = ADDR_W'(STORE_BYTES);
    localparam logic [8:0]        DIM_LIMIT   = 9'(MAX_TILE_DIM);

    logic [7:0]         mem [STORE_BYTES];

    logic [7:0]         x_reg;
    logic [7:0]         y_reg;
    logic [PIX_W-1:0]   i_reg;
    logic [YBASE_W-1:0] ybase_reg;
    logic [7:0]         rdata_reg;
    logic               pend_reg;
    logic               pend_ok_reg;
    logic [1:0]         pend_sel_reg;
    logic [7:0]         slot_reg [4];
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic [7:0]         alpha_reg;
    logic               oor_reg;

    logic [8:0]         w;
    logic [8:0]         h;
    logic               is_colour;
    logic               is_alpha;
    logic [16:0]        i_prod;
    logic [16:0]        i_sum;
    logic [16:0]        ybase_prod;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  colour_base;
    logic [ADDR_W-1:0]  alpha_word;
    logic [ADDR_W-1:0]  alpha_addr;
    logic [ADDR_W-1:0]  grey_byte;
    logic [ADDR_W-1:0]  rd_addr;
    logic [2:0]         bit_pos;
    logic [7:0]         grey_a;
    logic [7:0]         grey_v;

    // Tile size clamped to the largest tile
    assign w = (cfg.tile_width  > DIM_LIMIT) ? DIM_LIMIT : cfg.tile_width;
    assign h = (cfg.tile_height > DIM_LIMIT) ? DIM_LIMIT : cfg.tile_height;

    assign is_colour = cfg.channel_mode == MODE_COLOUR;
    assign is_alpha  = cfg.channel_mode == MODE_ALPHA;

    // Status to the controller
    assign stat.out_of_range = ({1'b0, x_reg} >= w) || ({1'b0, y_reg} >= h);
    always_comb
    begin
        if (is_colour)
        begin
            stat.last_sel = LAST_COLOUR;
        end
        else if (is_alpha)
        begin
            stat.last_sel = LAST_ALPHA;
        end
        else
        begin
            stat.last_sel = LAST_GREY;
        end
    end

    // Pixel index and alpha superpixel row base
    assign i_prod     = {9'd0, y_reg} * {8'd0, w};
    assign i_sum      = i_prod + {9'd0, x_reg};
    assign ybase_prod = {11'd0, y_reg[7:2]} * {8'd0, w};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg <= pixel_x;
            y_reg <= pixel_y;
        end
        if (ctl.calc)
        begin
            i_reg     <= i_sum[PIX_W-1:0];
            ybase_reg <= ybase_prod[YBASE_W-1:0];
        end
    end

    // Read address per mode and fetch slot
    assign colour_base = ADDR_W'(w) * ADDR_W'(ALPHA_TILE * 4) + ADDR_W'({i_reg, 2'b00});
    assign alpha_word  = ADDR_W'(ybase_reg)
                       + ADDR_W'(y_reg[1:0]) * ADDR_W'(ALPHA_TILE)
                       + ADDR_W'(x_reg[7:2]);
    assign alpha_addr  = {alpha_word[ADDR_W-3:0], x_reg[1:0]};
    assign grey_byte   = cfg.one_bit ? ADDR_W'(i_reg[PIX_W-1:3]) : ADDR_W'(i_reg);

    always_comb
    begin
        if (is_colour)
        begin
            case (ctl.rd_sel)
                SLOT_BLUE:  rd_addr = colour_base;
                SLOT_GREEN: rd_addr = colour_base + ADDR_W'(1);
                SLOT_RED:   rd_addr = colour_base + ADDR_W'(2);
                default:    rd_addr = alpha_addr;
            endcase
        end
        else if (is_alpha)
        begin
            rd_addr = ADDR_W'(i_reg);
        end
        else if (ctl.rd_sel == 2'd0)
        begin
            rd_addr = grey_byte;
        end
        else
        begin
            rd_addr = grey_byte + ADDR_W'(cfg.plane_bytes);
        end
    end

    assign wr_addr = ADDR_W'(byte_index);

    // Byte store
    always_ff @(posedge clk)
    begin
        if (ctl.mem_wr && wr_addr < STORE_LIMIT)
        begin
            mem[wr_addr[AW-1:0]] <= byte_value;
        end
        if (ctl.rd_en && rd_addr < STORE_LIMIT)
        begin
            rdata_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    // Track the read in flight; bytes past the store read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= ctl.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_sel_reg <= ctl.rd_sel;
        pend_ok_reg  <= rd_addr < STORE_LIMIT;
        if (pend_reg)
        begin
            slot_reg[pend_sel_reg] <= pend_ok_reg ? rdata_reg : 8'd0;
        end
    end

    // Grey decode, one bit per pixel MSB first
    assign bit_pos = ~i_reg[2:0];
    assign grey_a  = cfg.one_bit ? {8{slot_reg[0][bit_pos]}} : slot_reg[0];
    assign grey_v  = cfg.one_bit ? {8{slot_reg[1][bit_pos]}} : slot_reg[1];

    // Result registers
    always_ff @(posedge clk)
    begin
        if (ctl.result)
        begin
            oor_reg <= stat.out_of_range;
            if (stat.out_of_range)
            begin
                red_reg   <= 8'd0;
                green_reg <= 8'd0;
                blue_reg  <= 8'd0;
                alpha_reg <= 8'd0;
            end
            else if (is_colour)
            begin
                red_reg   <= slot_reg[SLOT_RED];
                green_reg <= slot_reg[SLOT_GREEN];
                blue_reg  <= slot_reg[SLOT_BLUE];
                alpha_reg <= slot_reg[SLOT_ALPHA];
            end
            else if (is_alpha)
            begin
                red_reg   <= 8'd255;
                green_reg <= 8'd255;
                blue_reg  <= 8'd255;
                alpha_reg <= slot_reg[0];
            end
            else
            begin
                red_reg   <= grey_v;
                green_reg <= grey_v;
                blue_reg  <= grey_v;
                alpha_reg <= grey_a;
            end
        end
    end

    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;
    assign out_of_range = oor_reg;

endmodule

>>> rtl/tile_pixel_unpacker_unit.sv
// ============================================================================
// tile_pixel_unpacker_unit - tile byte store with RGBA pixel reads
// Top level: configuration registers, transaction controller and datapath.
// ============================================================================
// A command is taken when start is high and busy is low. A byte write is
// stored at once and leaves busy low, so writes can be issued every cycle.
// A pixel read raises busy and returns one result, marked by done for a
// single cycle; the receiver cannot stall, so the result must be taken in
// that cycle. The byte store has one port and reads one byte per cycle, so
// a read steps through the index multiply, one fetch per byte (4 bytes in
// colour mode, 2 in grey mode, 1 in alpha-only mode), a drain state that
// lands the data and a result state that formats it, before done is raised.
// A pixel outside the tile skips the fetch and drain states.
// Store bytes never written read back undefined data. Configuration may only
// be written while no read is in flight.
// ============================================================================
module tile_pixel_unpacker_unit
    import tpu_pkg::*;
#(
    parameter int STORE_BYTES  = 524288,
    parameter int MAX_TILE_DIM = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  op,
    input  logic [18:0]           byte_index,
    input  logic [7:0]            byte_value,
    input  logic [7:0]            pixel_x,
    input  logic [7:0]            pixel_y,
    output logic                  done,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic [7:0]            alpha,
    output logic                  out_of_range,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    ctl_t  ctl;
    stat_t stat;

    tpu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .ctl   (ctl)
    );

    tpu_datapath #(
        .STORE_BYTES  (STORE_BYTES),
        .MAX_TILE_DIM (MAX_TILE_DIM)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .ctl          (ctl),
        .stat         (stat),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .out_of_range (out_of_range)
    );

endmodule
